>>> design/hcbp_pkg.sv
// Package for the Huffman code bit packer.
// Holds request codes, the sequencer state type and shared widths; no dependencies.
`default_nettype none

package hcbp_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_CODE_LEN_DEFAULT = 32;
   localparam int SYMBOLS_DEFAULT      = 256;

   // Fixed field widths.
   localparam int CODE_WIDTH  = 32;
   localparam int LEN_WIDTH   = 6;
   localparam int SYM_WIDTH   = 8;
   localparam int BYTE_BITS   = 8;
   localparam int PEND_WIDTH  = 7;
   localparam int COUNT_WIDTH = 3;
   localparam int ENTRY_WIDTH = CODE_WIDTH + LEN_WIDTH;
   // A full code plus the pending bits.
   localparam int ACC_WIDTH   = CODE_WIDTH + PEND_WIDTH;
   localparam int TOTAL_WIDTH = 6;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   // Encode sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> design/hcbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: code table RAM and byte packer.
// Depends on hcbp_pkg and hcbp_ram.
`default_nettype none

// A request transfers when start is high and busy is low. A load writes the
// code table in the transfer cycle and a flush emits its byte, if any, in the
// next cycle; both leave busy low. An encode reads the code table RAM and packs
// in the lookup state, then emits one byte per cycle from the packing register
// while busy stays high; an encode gives 0..4 bytes.
// Results appear on rsp_strobe for exactly one cycle and cannot be held off;
// rsp_last_of_run marks the final byte of a request. Encoding a symbol whose
// entry was never loaded gives undefined bytes.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT,
   parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_type,
   input  wire logic [hcbp_pkg::SYM_WIDTH-1:0]   req_symbol,
   input  wire logic [hcbp_pkg::CODE_WIDTH-1:0]  req_code_bits,
   input  wire logic [hcbp_pkg::LEN_WIDTH-1:0]   req_code_len,
   output logic                                  rsp_strobe,
   output logic [hcbp_pkg::BYTE_BITS-1:0]        rsp_packed_byte,
   output logic                                  rsp_last_of_run
);

   localparam int ADDR_WIDTH = $clog2(SYMBOLS);
   localparam int LEN_CAP    = (MAX_CODE_LEN < hcbp_pkg::CODE_WIDTH) ?
                               MAX_CODE_LEN : hcbp_pkg::CODE_WIDTH;

   hcbp_pkg::state_type state_ff, state_in;

   logic [hcbp_pkg::ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [hcbp_pkg::TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [hcbp_pkg::PEND_WIDTH-1:0]  pend_bits_ff, pend_bits_in;
   logic [hcbp_pkg::COUNT_WIDTH-1:0] pend_count_ff, pend_count_in;
   logic                             sym_ok_ff, sym_ok_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   logic [hcbp_pkg::BYTE_BITS-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                                accept;
   logic                                sym_ok;
   logic [ADDR_WIDTH-1:0]               addr;
   logic                                wr_en;
   logic                                rd_en;
   logic [hcbp_pkg::LEN_WIDTH-1:0]      load_len;
   logic [hcbp_pkg::CODE_WIDTH-1:0]     load_code;
   logic [hcbp_pkg::ENTRY_WIDTH-1:0]    wr_data;
   logic [hcbp_pkg::ENTRY_WIDTH-1:0]    rd_data;
   logic [hcbp_pkg::LEN_WIDTH-1:0]      entry_len;
   logic [hcbp_pkg::CODE_WIDTH-1:0]     entry_code;
   logic [hcbp_pkg::TOTAL_WIDTH-1:0]    remain;

   // Request decode.
   assign accept = start && !busy;
   assign sym_ok = {1'b0, req_symbol} < 9'(SYMBOLS);
   assign addr   = req_symbol[ADDR_WIDTH-1:0];

   // Table entry for a load: saturate the length, drop code bits above it.
   assign load_len  = (req_code_len > hcbp_pkg::LEN_WIDTH'(LEN_CAP)) ?
                      hcbp_pkg::LEN_WIDTH'(LEN_CAP) : req_code_len;
   assign load_code = req_code_bits & ~({hcbp_pkg::CODE_WIDTH{1'b1}} << load_len);
   assign wr_data   = {load_len, load_code};
   assign wr_en     = accept && (req_type == hcbp_pkg::REQ_LOAD) && sym_ok;
   assign rd_en     = accept && (req_type == hcbp_pkg::REQ_ENCODE);

   hcbp_ram #(
      .WIDTH (hcbp_pkg::ENTRY_WIDTH),
      .DEPTH (SYMBOLS)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // An out-of-table symbol reads as an empty code.
   assign entry_len  = sym_ok_ff ?
                       rd_data[hcbp_pkg::ENTRY_WIDTH-1:hcbp_pkg::CODE_WIDTH] : '0;
   assign entry_code = sym_ok_ff ? rd_data[hcbp_pkg::CODE_WIDTH-1:0] : '0;

   // Bits left after the byte that the emit state takes out.
   assign remain     = total_ff - hcbp_pkg::TOTAL_WIDTH'(hcbp_pkg::BYTE_BITS);

   // State register and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hcbp_pkg::ST_IDLE;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      sym_ok_ff   <= sym_ok_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Next state, packing and result generation.
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;
      sym_ok_in     = sym_ok_ff;
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  hcbp_pkg::REQ_ENCODE: begin
                     sym_ok_in = sym_ok;
                     state_in  = hcbp_pkg::ST_LOOKUP;
                  end
                  hcbp_pkg::REQ_FLUSH: begin
                     // Pad the partial byte with zeros at the bottom.
                     if (pend_count_ff != '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_byte_in   = hcbp_pkg::BYTE_BITS'(
                           {pend_bits_ff, 1'b0} << (hcbp_pkg::PEND_WIDTH - 32'(pend_count_ff)));
                        rsp_last_in   = 1'b1;
                     end
                     pend_bits_in  = '0;
                     pend_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         hcbp_pkg::ST_LOOKUP: begin
            // Append the code below the pending bits.
            acc_in   = (hcbp_pkg::ACC_WIDTH'(pend_bits_ff) << entry_len) |
                       hcbp_pkg::ACC_WIDTH'(entry_code);
            total_in = hcbp_pkg::TOTAL_WIDTH'(pend_count_ff) + entry_len;
            state_in = hcbp_pkg::ST_EMIT;
         end

         hcbp_pkg::ST_EMIT: begin
            if (total_ff >= hcbp_pkg::TOTAL_WIDTH'(hcbp_pkg::BYTE_BITS)) begin
               // Take the oldest complete byte.
               rsp_strobe_in = 1'b1;
               rsp_byte_in   = hcbp_pkg::BYTE_BITS'(acc_ff >> remain);
               rsp_last_in   = remain < hcbp_pkg::TOTAL_WIDTH'(hcbp_pkg::BYTE_BITS);
               total_in      = remain;
               if (remain < hcbp_pkg::TOTAL_WIDTH'(hcbp_pkg::BYTE_BITS)) begin
                  pend_bits_in  = acc_ff[hcbp_pkg::PEND_WIDTH-1:0] &
                                  ~({hcbp_pkg::PEND_WIDTH{1'b1}} << remain);
                  pend_count_in = remain[hcbp_pkg::COUNT_WIDTH-1:0];
                  state_in      = hcbp_pkg::ST_IDLE;
               end
            end else begin
               // Fewer than eight bits in all: keep them pending.
               pend_bits_in  = acc_ff[hcbp_pkg::PEND_WIDTH-1:0] &
                               ~({hcbp_pkg::PEND_WIDTH{1'b1}} << total_ff);
               pend_count_in = total_ff[hcbp_pkg::COUNT_WIDTH-1:0];
               state_in      = hcbp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hcbp_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   assign busy            = (state_ff != hcbp_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire
